// ===== sv/sine_cosine_taylor_unit_macros.svh =====
// Assertion macros shared by the sine and cosine unit.
// Depends on nothing; included by the files that check their own logic.
`ifndef SINE_COSINE_TAYLOR_UNIT_MACROS_SVH
`define SINE_COSINE_TAYLOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define SCT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sct: same-cycle check failed");

// Next-cycle implication.
`define SCT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sct: next-cycle check failed");

`endif

// ===== sv/sct_pkg.sv =====
// Types, constants and arithmetic helpers of the sine and cosine unit.
// Depends on nothing; used by sct_horner and sine_cosine_taylor_unit.
`timescale 1ns / 1ps

package sct_pkg;

    localparam int FRAC_BITS    = 24;
    localparam int ANGLE_W      = 40;
    localparam int VALUE_W      = 32;
    localparam int TERMS        = 6;
    localparam int HORNER_STEPS = TERMS - 1;
    localparam int STEP_W       = 3;
    localparam int Q40          = 40;
    localparam int Q40_SHIFT    = Q40 - FRAC_BITS;
    localparam int MAG_W        = 26;
    localparam int XM_W         = MAG_W + Q40_SHIFT;
    localparam int OPND_W       = 44;
    localparam int HALF_W       = OPND_W / 2;
    localparam int X2_W         = OPND_W;
    localparam int ACC_W        = OPND_W;
    localparam int Q_W          = 48;
    localparam int SUM_W        = 2 * OPND_W;
    localparam int RED_STEPS    = 13;
    localparam int DIV_W        = 7;
    localparam int CHUNK_W      = 16;
    localparam int RECIP_W      = 30;
    localparam int RECIP_SHIFT  = 30;
    localparam int V_W          = DIV_W + CHUNK_W;
    localparam int PROD_W       = V_W + RECIP_W;
    localparam int OUT_SHIFT    = Q40 - 30;

    localparam logic [63:0] PI_Q61 = 64'h6487_ED51_10B4_611A;
    localparam logic [ANGLE_W-1:0] PI_F =
        ANGLE_W'((PI_Q61 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS));
    localparam logic [ANGLE_W-1:0] TWO_PI_F =
        ANGLE_W'((PI_Q61 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
    localparam logic [ACC_W-1:0] ONE_Q40 = ACC_W'(1) << Q40;

    // Horner step s works on the term n = TERMS - 1 - s.
    localparam logic [DIV_W-1:0] DIV_SIN [HORNER_STEPS] =
        '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [DIV_W-1:0] DIV_COS [HORNER_STEPS] =
        '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
    localparam logic [RECIP_W-1:0] RECIP_SIN [HORNER_STEPS] = '{
        30'(((2 ** 30) + 110 - 1) / 110), 30'(((2 ** 30) + 72 - 1) / 72),
        30'(((2 ** 30) + 42 - 1) / 42), 30'(((2 ** 30) + 20 - 1) / 20),
        30'(((2 ** 30) + 6 - 1) / 6)};
    localparam logic [RECIP_W-1:0] RECIP_COS [HORNER_STEPS] = '{
        30'(((2 ** 30) + 90 - 1) / 90), 30'(((2 ** 30) + 56 - 1) / 56),
        30'(((2 ** 30) + 30 - 1) / 30), 30'(((2 ** 30) + 12 - 1) / 12),
        30'(((2 ** 30) + 2 - 1) / 2)};

    typedef struct packed {
        logic              valid;
        logic              cosine;
        logic              neg;
        logic              flip;
        logic [XM_W-1:0]   xm;
        logic [X2_W-1:0]   x2;
        logic              acc_neg;
        logic [ACC_W-1:0]  accm;
    } item_t;

    typedef struct packed {
        logic [OPND_W-1:0] p00;
        logic [OPND_W-1:0] p01;
        logic [OPND_W-1:0] p10;
        logic [OPND_W-1:0] p11;
    } pp_t;

    function automatic logic [DIV_W-1:0] div_of(logic [STEP_W-1:0] s, logic cosine);
        return cosine ? DIV_COS[s] : DIV_SIN[s];
    endfunction

    function automatic logic [RECIP_W-1:0] recip_of(logic [STEP_W-1:0] s, logic cosine);
        return cosine ? RECIP_COS[s] : RECIP_SIN[s];
    endfunction

    // Four half-width partial products of two unsigned magnitudes.
    function automatic pp_t mul_pp(logic [OPND_W-1:0] a, logic [OPND_W-1:0] b);
        pp_t p;
        p.p00 = OPND_W'(a[HALF_W-1:0])      * OPND_W'(b[HALF_W-1:0]);
        p.p01 = OPND_W'(a[HALF_W-1:0])      * OPND_W'(b[OPND_W-1:HALF_W]);
        p.p10 = OPND_W'(a[OPND_W-1:HALF_W]) * OPND_W'(b[HALF_W-1:0]);
        p.p11 = OPND_W'(a[OPND_W-1:HALF_W]) * OPND_W'(b[OPND_W-1:HALF_W]);
        return p;
    endfunction

    // Sum of the partial products, rounded from Q80 to Q40, half away from zero.
    function automatic logic [Q_W-1:0] pp_round(pp_t p);
        logic [SUM_W-1:0] s;
        s = {p.p11, {OPND_W{1'b0}}} + (SUM_W'(p.p01) << HALF_W)
            + (SUM_W'(p.p10) << HALF_W) + SUM_W'(p.p00) + (SUM_W'(1) << (Q40 - 1));
        return s[Q40 +: Q_W];
    endfunction

endpackage

// ===== sv/sine_cosine_taylor_unit.sv =====
// Top level of the sine and cosine unit: range reduction, Horner chain, output skid.
// Depends on sct_pkg, sct_horner and the assertion macros.
//
//   Group   Direction  Payload
//   s_      in         tdata[39:0] angle (Q16.24, signed); tuser[0] func (0 sine, 1 cosine)
//   m_      out        tdata[31:0] value (Q2.30, signed, saturated)
//
// One request is taken every cycle while s_tready is high.
// The pipeline holds 13 range-reduction stages and 5 Horner steps of 8 stages each.
// Reset clears only the valid bits of the stages and of the output registers.
// A stalled result waits in the output register; one more result fits in the skid
// register, and only then does s_tready fall.
`timescale 1ns / 1ps
`include "sine_cosine_taylor_unit_macros.svh"

module sine_cosine_taylor_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sct_pkg::ANGLE_W-1:0]   s_tdata,   // [39:0] angle
    input  logic                          s_tuser,   // [0] func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sct_pkg::VALUE_W-1:0]   m_tdata    // [31:0] value
);

    typedef struct packed {
        logic                        valid;
        logic                        cosine;
        logic                        neg;
        logic                        zero;
        logic [sct_pkg::ANGLE_W-1:0] rem;
    } red_t;

    typedef struct packed {
        logic                        valid;
        logic [sct_pkg::VALUE_W-1:0] value;
    } fin_t;

    logic                          en;
    red_t                          red_reg [0:sct_pkg::RED_STEPS];
    sct_pkg::item_t                xs_reg;
    sct_pkg::item_t                m1_reg;
    sct_pkg::pp_t                  m1_pp_reg;
    sct_pkg::item_t                h_item [0:sct_pkg::HORNER_STEPS];
    sct_pkg::item_t                f1_reg;
    sct_pkg::pp_t                  f1_pp_reg;
    logic                          f2_valid_reg;
    logic                          f2_sgn_reg;
    logic [sct_pkg::Q_W-1:0]       f2_mag_reg;
    fin_t                          fin_reg;
    logic                          m_valid_reg;
    logic [sct_pkg::VALUE_W-1:0]   m_data_reg;
    logic                          skid_valid_reg;
    logic [sct_pkg::VALUE_W-1:0]   skid_data_reg;

    red_t                          red_next;
    sct_pkg::item_t                xs_next;
    logic [sct_pkg::ANGLE_W-1:0]   mag;
    sct_pkg::item_t                h0_next;
    logic                          f2_sgn_next;
    logic [sct_pkg::Q_W-1:0]       f2_mag_next;
    logic [sct_pkg::Q_W:0]         rnd_sum;
    logic [sct_pkg::Q_W-sct_pkg::OUT_SHIFT:0] q30;
    fin_t                          fin_next;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_comb begin
        red_next.valid  = s_tvalid;
        red_next.cosine = s_tuser;
        red_next.neg    = s_tdata[sct_pkg::ANGLE_W-1];
        red_next.zero   = (s_tdata == '0);
        if (red_next.zero) begin
            red_next.rem = '0;
        end else if (red_next.neg) begin
            red_next.rem = ~s_tdata;
        end else begin
            red_next.rem = s_tdata - sct_pkg::ANGLE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_reg[0].valid <= 1'b0;
        end else if (en) begin
            red_reg[0] <= red_next;
        end
    end

    for (genvar g = 0; g < sct_pkg::RED_STEPS; g++) begin : g_red
        localparam logic [sct_pkg::ANGLE_W-1:0] STEP_SUB =
            sct_pkg::TWO_PI_F << (sct_pkg::RED_STEPS - 1 - g);
        logic [sct_pkg::ANGLE_W:0] diff;
        red_t                      stage_next;

        always_comb begin
            diff       = {1'b0, red_reg[g].rem} - {1'b0, STEP_SUB};
            stage_next = red_reg[g];
            if (!diff[sct_pkg::ANGLE_W]) begin
                stage_next.rem = diff[sct_pkg::ANGLE_W-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                red_reg[g+1].valid <= 1'b0;
            end else if (en) begin
                red_reg[g+1] <= stage_next;
            end
        end
    end

    always_comb begin
        xs_next         = '0;
        xs_next.valid   = red_reg[sct_pkg::RED_STEPS].valid;
        xs_next.cosine  = red_reg[sct_pkg::RED_STEPS].cosine;
        xs_next.neg     = red_reg[sct_pkg::RED_STEPS].neg;
        mag             = '0;
        if (!red_reg[sct_pkg::RED_STEPS].zero) begin
            if (red_reg[sct_pkg::RED_STEPS].rem >= sct_pkg::PI_F) begin
                mag          = red_reg[sct_pkg::RED_STEPS].rem
                               - (sct_pkg::PI_F - sct_pkg::ANGLE_W'(1));
                xs_next.flip = 1'b1;
            end else begin
                mag = red_reg[sct_pkg::RED_STEPS].rem + sct_pkg::ANGLE_W'(1);
            end
        end
        xs_next.xm = {mag[sct_pkg::MAG_W-1:0], {sct_pkg::Q40_SHIFT{1'b0}}};
    end

    always_comb begin
        h0_next         = m1_reg;
        h0_next.x2      = sct_pkg::X2_W'(sct_pkg::pp_round(m1_pp_reg));
        h0_next.acc_neg = 1'b0;
        h0_next.accm    = sct_pkg::ONE_Q40;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xs_reg.valid     <= 1'b0;
            m1_reg.valid     <= 1'b0;
            h_item[0].valid  <= 1'b0;
        end else if (en) begin
            xs_reg    <= xs_next;
            m1_reg    <= xs_reg;
            h_item[0] <= h0_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_pp_reg <= sct_pkg::mul_pp(sct_pkg::OPND_W'(xs_reg.xm),
                                         sct_pkg::OPND_W'(xs_reg.xm));
        end
    end

    for (genvar g = 0; g < sct_pkg::HORNER_STEPS; g++) begin : g_horner
        sct_horner u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .step_idx (sct_pkg::STEP_W'(g)),
            .in_item  (h_item[g]),
            .out_item (h_item[g+1])
        );
    end

    always_comb begin
        if (f1_reg.cosine) begin
            f2_sgn_next = f1_reg.acc_neg;
            f2_mag_next = sct_pkg::Q_W'(f1_reg.accm);
        end else begin
            f2_sgn_next = f1_reg.neg ^ f1_reg.acc_neg;
            f2_mag_next = sct_pkg::pp_round(f1_pp_reg);
        end
        f2_sgn_next = f2_sgn_next ^ f1_reg.flip;
    end

    always_comb begin
        rnd_sum        = {1'b0, f2_mag_reg} + (sct_pkg::Q_W'(1) << (sct_pkg::OUT_SHIFT - 1));
        q30            = rnd_sum[sct_pkg::Q_W:sct_pkg::OUT_SHIFT];
        fin_next.valid = f2_valid_reg;
        if (f2_sgn_reg) begin
            if (q30 > ($bits(q30))'(33'h1_0000_0000 >> 1)) begin
                fin_next.value = {1'b1, {(sct_pkg::VALUE_W-1){1'b0}}};
            end else begin
                fin_next.value = sct_pkg::VALUE_W'(0) - q30[sct_pkg::VALUE_W-1:0];
            end
        end else begin
            if (q30 > ($bits(q30))'({1'b0, {(sct_pkg::VALUE_W-1){1'b1}}})) begin
                fin_next.value = {1'b0, {(sct_pkg::VALUE_W-1){1'b1}}};
            end else begin
                fin_next.value = q30[sct_pkg::VALUE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_reg.valid  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            fin_reg.valid <= 1'b0;
        end else if (en) begin
            f1_reg       <= h_item[sct_pkg::HORNER_STEPS];
            f2_valid_reg <= f1_reg.valid;
            fin_reg      <= fin_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_pp_reg  <= sct_pkg::mul_pp(
                              sct_pkg::OPND_W'(h_item[sct_pkg::HORNER_STEPS].xm),
                              h_item[sct_pkg::HORNER_STEPS].accm);
            f2_sgn_reg <= f2_sgn_next;
            f2_mag_reg <= f2_mag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_valid_reg && !m_tready) begin
            if (en && fin_reg.valid) begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= fin_reg.value;
            end
        end else if (skid_valid_reg) begin
            m_valid_reg    <= 1'b1;
            m_data_reg     <= skid_data_reg;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= en && fin_reg.valid;
            m_data_reg  <= fin_reg.value;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `SCT_ASSERT_IMPL(a_skid_needs_main, aclk, aresetn, skid_valid_reg, m_valid_reg)
    `SCT_ASSERT_NEXT(a_skid_to_main, aclk, aresetn, skid_valid_reg && m_tready, m_valid_reg && (m_data_reg == $past(skid_data_reg)))
    `SCT_ASSERT_NEXT(a_stall_fills_skid, aclk, aresetn, m_valid_reg && !m_tready && en && fin_reg.valid, skid_valid_reg)
    `SCT_ASSERT_IMPL(a_reduced_range, aclk, aresetn, red_reg[sct_pkg::RED_STEPS].valid, red_reg[sct_pkg::RED_STEPS].rem < sct_pkg::TWO_PI_F)

endmodule

// ===== sv/sct_horner.sv =====
// One Horner step: acc = 1 - round(x2 * acc) / d, truncated toward zero.
// Depends on sct_pkg and the assertion macros; instanced by the top level.
`timescale 1ns / 1ps
`include "sine_cosine_taylor_unit_macros.svh"

module sct_horner (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic [sct_pkg::STEP_W-1:0]   step_idx,
    input  sct_pkg::item_t               in_item,
    output sct_pkg::item_t               out_item
);

    sct_pkg::item_t                       itm_reg [1:7];
    sct_pkg::item_t                       out_reg;
    sct_pkg::pp_t                         pp1_reg;
    logic [sct_pkg::Q_W-1:0]              q2_reg;
    logic [sct_pkg::PROD_W-1:0]           p3_reg;
    logic [sct_pkg::CHUNK_W-1:0]          hi3_reg;
    logic [2*sct_pkg::CHUNK_W-1:0]        lo3_reg;
    logic [sct_pkg::CHUNK_W-1:0]          qa4_reg;
    logic [sct_pkg::DIV_W-1:0]            r4_reg;
    logic [2*sct_pkg::CHUNK_W-1:0]        lo4_reg;
    logic [sct_pkg::PROD_W-1:0]           p5_reg;
    logic [sct_pkg::V_W-1:0]              v5_reg;
    logic [sct_pkg::CHUNK_W-1:0]          qa5_reg;
    logic [sct_pkg::CHUNK_W-1:0]          lo5_reg;
    logic [sct_pkg::CHUNK_W-1:0]          qa6_reg;
    logic [sct_pkg::CHUNK_W-1:0]          qb6_reg;
    logic [sct_pkg::DIV_W-1:0]            r6_reg;
    logic [sct_pkg::CHUNK_W-1:0]          lo6_reg;
    logic [sct_pkg::PROD_W-1:0]           p7_reg;
    logic [sct_pkg::CHUNK_W-1:0]          qa7_reg;
    logic [sct_pkg::CHUNK_W-1:0]          qb7_reg;

    logic [sct_pkg::CHUNK_W-1:0]          qa4_next;
    logic [sct_pkg::V_W-1:0]              r4_full;
    logic [sct_pkg::V_W-1:0]              v5_next;
    logic [sct_pkg::CHUNK_W-1:0]          qb6_next;
    logic [sct_pkg::V_W-1:0]              r6_full;
    logic [sct_pkg::V_W-1:0]              v7_next;
    logic [sct_pkg::Q_W-1:0]              quot;
    logic [sct_pkg::Q_W-1:0]              one_w;
    sct_pkg::item_t                       out_next;

    always_comb begin
        qa4_next = p3_reg[sct_pkg::RECIP_SHIFT +: sct_pkg::CHUNK_W];
        r4_full  = sct_pkg::V_W'(hi3_reg) - sct_pkg::V_W'(qa4_next)
                   * sct_pkg::V_W'(sct_pkg::div_of(step_idx, itm_reg[3].cosine));
        v5_next  = {r4_reg, lo4_reg[2*sct_pkg::CHUNK_W-1:sct_pkg::CHUNK_W]};
        qb6_next = p5_reg[sct_pkg::RECIP_SHIFT +: sct_pkg::CHUNK_W];
        r6_full  = v5_reg - sct_pkg::V_W'(qb6_next)
                   * sct_pkg::V_W'(sct_pkg::div_of(step_idx, itm_reg[5].cosine));
        v7_next  = {r6_reg, lo6_reg};
        quot     = {qa7_reg, qb7_reg, p7_reg[sct_pkg::RECIP_SHIFT +: sct_pkg::CHUNK_W]};
        one_w    = sct_pkg::Q_W'(sct_pkg::ONE_Q40);
        out_next = itm_reg[7];
        if (itm_reg[7].acc_neg) begin
            out_next.acc_neg = 1'b0;
            out_next.accm    = sct_pkg::ACC_W'(one_w + quot);
        end else if (quot <= one_w) begin
            out_next.acc_neg = 1'b0;
            out_next.accm    = sct_pkg::ACC_W'(one_w - quot);
        end else begin
            out_next.acc_neg = 1'b1;
            out_next.accm    = sct_pkg::ACC_W'(quot - one_w);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= 7; i++) begin
                itm_reg[i].valid <= 1'b0;
            end
            out_reg.valid <= 1'b0;
        end else if (en) begin
            itm_reg[1] <= in_item;
            for (int i = 2; i <= 7; i++) begin
                itm_reg[i] <= itm_reg[i-1];
            end
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp1_reg <= sct_pkg::mul_pp(in_item.x2, in_item.accm);
            q2_reg  <= sct_pkg::pp_round(pp1_reg);
            p3_reg  <= sct_pkg::PROD_W'(q2_reg[sct_pkg::Q_W-1 -: sct_pkg::CHUNK_W])
                       * sct_pkg::PROD_W'(sct_pkg::recip_of(step_idx, itm_reg[2].cosine));
            hi3_reg <= q2_reg[sct_pkg::Q_W-1 -: sct_pkg::CHUNK_W];
            lo3_reg <= q2_reg[2*sct_pkg::CHUNK_W-1:0];
            qa4_reg <= qa4_next;
            r4_reg  <= r4_full[sct_pkg::DIV_W-1:0];
            lo4_reg <= lo3_reg;
            p5_reg  <= sct_pkg::PROD_W'(v5_next)
                       * sct_pkg::PROD_W'(sct_pkg::recip_of(step_idx, itm_reg[4].cosine));
            v5_reg  <= v5_next;
            qa5_reg <= qa4_reg;
            lo5_reg <= lo4_reg[sct_pkg::CHUNK_W-1:0];
            qa6_reg <= qa5_reg;
            qb6_reg <= qb6_next;
            r6_reg  <= r6_full[sct_pkg::DIV_W-1:0];
            lo6_reg <= lo5_reg;
            p7_reg  <= sct_pkg::PROD_W'(v7_next)
                       * sct_pkg::PROD_W'(sct_pkg::recip_of(step_idx, itm_reg[6].cosine));
            qa7_reg <= qa6_reg;
            qb7_reg <= qb6_reg;
        end
    end

    assign out_item = out_reg;

    `SCT_ASSERT_IMPL(a_rem_upper, aclk, aresetn, itm_reg[4].valid, r4_reg < sct_pkg::div_of(step_idx, itm_reg[4].cosine))
    `SCT_ASSERT_IMPL(a_rem_middle, aclk, aresetn, itm_reg[6].valid, r6_reg < sct_pkg::div_of(step_idx, itm_reg[6].cosine))
    `SCT_ASSERT_IMPL(a_quot_upper, aclk, aresetn, itm_reg[4].valid, (32'(qa4_reg) * 32'(sct_pkg::div_of(step_idx, itm_reg[4].cosine))) <= 32'(itm_reg[4].valid ? 16'hFFFF : 16'h0000))

endmodule
